FILE: rtl/token_bucket_limiter_defines.svh
// assertion macros for the token bucket checker
`ifndef TOKEN_BUCKET_LIMITER_DEFINES_SVH
`define TOKEN_BUCKET_LIMITER_DEFINES_SVH

// antecedent in one cycle, consequent from the next
`define TBL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbl_checker: property failed");

// value held over the next cycle
`define TBL_ASSERT_HOLD(lbl, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error("tbl_checker: held value changed");

`endif

FILE: rtl/tbl_pkg.sv
`default_nettype none

package tbl_pkg;

	localparam int TOKEN_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_TIME     = 3'd0,
		REG_CAPACITY       = 3'd1,
		REG_QUANTUM        = 3'd2,
		REG_TICK_PERIOD    = 3'd3,
		REG_INITIAL_TOKENS = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] now_ns;
		logic [15:0] request_count;
	} in_item_t;

	typedef struct packed {
		logic [15:0] granted;
		logic [31:0] remaining;
	} out_item_t;

	typedef struct packed {
		logic [63:0] tick;
		logic [15:0] request_count;
	} tick_item_t;

	typedef struct packed {
		logic [63:0] start_time;
		logic [31:0] capacity;
		logic [31:0] quantum;
		logic [39:0] tick_period;
	} cfg_regs_t;

	typedef struct packed {
		logic        load;
		logic [31:0] value;
	} token_load_t;

endpackage

`default_nettype wire

FILE: rtl/token_bucket_limiter.sv
// Token bucket policer. Each request carries the time in ns and a token count; the
// block refills the bucket from the fill ticks elapsed since the last nonzero request, grants
// at most the tokens held and reports the grant and the tokens left. The front end
// turns elapsed time into ticks with a 64-step divider for a request with a nonzero
// count and takes no new request until it has handed the ticks on; a zero request
// skips the divider. The back end applies refill and grant through its MUL and UPD
// states, so it keeps up with the divider; a full result queue stalls the back end and
// then the front end. Config writes are always taken and should be made only while the
// block is idle; a write to initial_tokens also loads the bucket.
`default_nettype none

module token_bucket_limiter #(
	parameter int TOKEN_WIDTH = tbl_pkg::TOKEN_WIDTH_DEF,
	parameter int QUEUE_DEPTH = tbl_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire tbl_pkg::in_item_t                 item,
	output logic                                   empty,
	input  wire logic                              pop,
	output tbl_pkg::out_item_t                     result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tbl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [63:0]                       cfg_data
);

	tbl_pkg::cfg_regs_t   cfg_q;
	tbl_pkg::token_load_t load;
	logic                 cfg_we;

	logic                 mid_push;
	logic                 mid_full;
	logic                 mid_pop;
	logic                 mid_empty;
	tbl_pkg::tick_item_t  mid_wdata;
	tbl_pkg::tick_item_t  mid_rdata;

	logic                 res_push;
	logic                 res_full;
	tbl_pkg::out_item_t   res_wdata;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign load.load  = cfg_we && (cfg_index == tbl_pkg::REG_INITIAL_TOKENS);
	assign load.value = cfg_data[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_time  <= '0;
			cfg_q.capacity    <= '0;
			cfg_q.quantum     <= '0;
			cfg_q.tick_period <= 40'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbl_pkg::REG_START_TIME:  cfg_q.start_time  <= cfg_data;
				tbl_pkg::REG_CAPACITY:    cfg_q.capacity    <= cfg_data[31:0];
				tbl_pkg::REG_QUANTUM:     cfg_q.quantum     <= cfg_data[31:0];
				tbl_pkg::REG_TICK_PERIOD: cfg_q.tick_period <= cfg_data[39:0];
				default: begin
				end
			endcase
		end
	end

	tbl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.cfg    (cfg_q),
		.q_push (mid_push),
		.q_data (mid_wdata),
		.q_full (mid_full)
	);

	tbl_fifo #(
		.WIDTH ($bits(tbl_pkg::tick_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	tbl_back #(
		.TOKEN_WIDTH (TOKEN_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.load    (load),
		.q_empty (mid_empty),
		.q_pop   (mid_pop),
		.q_data  (mid_rdata),
		.r_full  (res_full),
		.r_push  (res_push),
		.r_data  (res_wdata)
	);

	tbl_fifo #(
		.WIDTH ($bits(tbl_pkg::out_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

FILE: rtl/tbl_fifo.sv
`default_nettype none

module tbl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tbl_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tbl_front.sv
`default_nettype none

module tbl_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire tbl_pkg::in_item_t    item,
	input  wire tbl_pkg::cfg_regs_t   cfg,
	output logic                      q_push,
	output tbl_pkg::tick_item_t       q_data,
	input  wire logic                 q_full
);

	localparam int DIV_STEPS = 64;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		SEND
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      num_q;
	logic [39:0]      rem_q;
	logic [15:0]      req_q;

	logic [39:0] divisor;
	logic [40:0] rem_sh;
	logic        ge;
	logic [39:0] rem_nx;

	// zero interval counts as one
	assign divisor = (cfg.tick_period == '0) ? 40'd1 : cfg.tick_period;
	assign rem_sh  = {rem_q, num_q[63]};
	assign ge      = (rem_sh >= {1'b0, divisor});
	assign rem_nx  = ge ? 40'(rem_sh - {1'b0, divisor}) : rem_sh[39:0];

	assign full                 = (state_q != IDLE);
	assign q_push               = (state_q == SEND) && !q_full;
	assign q_data.tick          = num_q;
	assign q_data.request_count = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (push) begin
						num_q   <= item.now_ns - cfg.start_time;
						rem_q   <= '0;
						req_q   <= item.request_count;
						cnt_q   <= '0;
						state_q <= (item.request_count == '0) ? SEND : DIV;
					end
				end
				DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q <= rem_nx;
					num_q <= {num_q[62:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= SEND;
					end
				end
				SEND: begin
					if (!q_full) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tbl_back.sv
`default_nettype none

module tbl_back #(
	parameter int TOKEN_WIDTH = tbl_pkg::TOKEN_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tbl_pkg::cfg_regs_t    cfg,
	input  wire tbl_pkg::token_load_t  load,
	input  wire logic                  q_empty,
	output logic                       q_pop,
	input  wire tbl_pkg::tick_item_t   q_data,
	input  wire logic                  r_full,
	output logic                       r_push,
	output tbl_pkg::out_item_t         r_data
);

	typedef enum logic [1:0] {
		IDLE,
		MUL,
		UPD
	} state_t;

	state_t                 state_q;
	logic [TOKEN_WIDTH-1:0] tokens_q;
	logic [63:0]            last_tick_q;
	logic [63:0]            delta_q;
	logic [63:0]            prod_q;
	logic                   big_q;
	logic [15:0]            req_q;

	logic                   take;
	logic                   zero_req;
	logic [63:0]            mul_w;
	logic [TOKEN_WIDTH-1:0] cap;
	logic [TOKEN_WIDTH-1:0] room;
	logic [TOKEN_WIDTH-1:0] tok_fill;
	logic [TOKEN_WIDTH-1:0] tok_after;
	logic [15:0]            grant;

	assign take     = !q_empty && !r_full;
	assign zero_req = (q_data.request_count == '0);
	assign q_pop    = (state_q == IDLE) && take;
	assign mul_w    = 64'(delta_q[31:0]) * 64'(cfg.quantum);

	always_comb begin
		cap      = TOKEN_WIDTH'(cfg.capacity);
		room     = cap - tokens_q;
		tok_fill = tokens_q;
		if ((tokens_q < cap) && (cfg.quantum != '0)) begin
			if (big_q || (prod_q > 64'(room))) begin
				tok_fill = cap;
			end else begin
				tok_fill = tokens_q + TOKEN_WIDTH'(prod_q);
			end
		end
		grant     = (64'(tok_fill) < 64'(req_q)) ? 16'(tok_fill) : req_q;
		tok_after = tok_fill - TOKEN_WIDTH'(grant);
	end

	always_comb begin
		r_push = 1'b0;
		r_data = '0;
		if (state_q == UPD) begin
			r_push           = 1'b1;
			r_data.granted   = grant;
			r_data.remaining = 32'(tok_after);
		end else if ((state_q == IDLE) && take && zero_req) begin
			r_push           = 1'b1;
			r_data.remaining = 32'(tokens_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			tokens_q    <= '0;
			last_tick_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (take && !zero_req) begin
						delta_q     <= q_data.tick - last_tick_q;
						last_tick_q <= q_data.tick;
						req_q       <= q_data.request_count;
						state_q     <= MUL;
					end
				end
				MUL: begin
					prod_q  <= mul_w;
					big_q   <= |delta_q[63:32];
					state_q <= UPD;
				end
				UPD: begin
					tokens_q <= tok_after;
					state_q  <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (load.load) begin
				tokens_q <= TOKEN_WIDTH'(load.value);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tbl_checker.sv
`default_nettype none
`include "token_bucket_limiter_defines.svh"

module tbl_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               push,
	input wire logic               full,
	input wire tbl_pkg::in_item_t  item,
	input wire logic               empty,
	input wire logic               pop,
	input wire tbl_pkg::out_item_t result
);

	// one request at a time in the front end
	`TBL_ASSERT_NEXT(a_busy_after_accept, push && !full, full)

	// the front end is still busy at the first and at the last step of the divide for a nonzero request
	`TBL_ASSERT_NEXT(a_divide_length, push && !full && (item.request_count != '0), full ##63 full)

	`TBL_ASSERT_NEXT(a_result_kept, !empty && !pop, !empty)

	`TBL_ASSERT_HOLD(a_result_stable, !empty && !pop, result)

endmodule

bind token_bucket_limiter tbl_checker u_tbl_checker (.*);

`default_nettype wire
